### sv/ps2_device_scan_code_transmitter_defines.svh
// ----------------------------------------------------------------------------
// ps2 device transmitter assertion macros
// shared concurrent assertion shorthands, clocked on clk_i, reset on rst_ni
// ----------------------------------------------------------------------------
`ifndef PS2_DEVICE_SCAN_CODE_TRANSMITTER_DEFINES_SVH
`define PS2_DEVICE_SCAN_CODE_TRANSMITTER_DEFINES_SVH

// property checked outside reset
`define PS2DT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked outside reset
`define PS2DT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication on the following cycle, checked outside reset
`define PS2DT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ps2dt_pkg.sv
// ----------------------------------------------------------------------------
// ps2dt_pkg
// types, constants and helpers of the ps2 device scan code transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package ps2dt_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned CFG_W   = 20;

  // register index, taken from paddr[2]
  localparam logic REG_CLOCK_PERIOD = 1'b0;
  localparam logic REG_PRETRANSMIT  = 1'b1;

  localparam logic [CFG_W-1:0] CLOCK_PERIOD_RST = 20'd59880;
  localparam logic [CFG_W-1:0] PRETRANSMIT_RST  = 20'd50000;

  localparam logic [7:0] PREFIX_EXTENDED = 8'hE0;
  localparam logic [7:0] PREFIX_BREAK    = 8'hF0;
  localparam logic [7:0] BYTE_END        = 8'h00;
  localparam logic [3:0] FRAME_END       = 4'd10;
  localparam int unsigned SEQ_DEPTH      = 4;

  typedef enum logic [2:0] {
    PH_INHIBIT  = 3'd0,
    PH_PRETX    = 3'd1,
    PH_DATA     = 3'd2,
    PH_CLKLOW   = 3'd3,
    PH_CLKHIGH  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [15:0] step_ns;
    logic        host_clock_level;
    logic        host_data_level;
    logic        key_valid;
    logic        key_release;
    logic        key_extended;
    logic [7:0]  key_code;
  } in_word_t;

  typedef struct packed {
    logic       clock_line;
    logic       data_line;
    logic       key_taken;
    logic [2:0] phase;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] clock_period_ns;
    logic [CFG_W-1:0] pretransmit_ns;
  } cfg_t;

  // odd parity over one data byte
  function automatic logic odd_parity(input logic [7:0] v);
    return ~(^v);
  endfunction

endpackage

`default_nettype wire

### sv/ps2_device_scan_code_transmitter.sv
// ----------------------------------------------------------------------------
// ps2_device_scan_code_transmitter
// ps2 keyboard device side sender driven by time ticks, with apb setup
// ----------------------------------------------------------------------------
// each input word is one time tick: nanoseconds since the previous tick, the
// host's clock and data drive, and an optional key event; each tick yields
// exactly one result word with the wired-and line levels, a key-taken flag and
// the sender phase after the tick. one word is taken every clock cycle while
// the result side does not stall. an accepted word sits in the input register,
// and its result is then loaded into the result register, from which it is
// taken. the whole update of the phase and the 32-bit elapsed timer fits
// between the two registers. a stalled result holds the input register, which
// then stalls the input. the two timing registers are to be written over apb
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module ps2_device_scan_code_transmitter
  import ps2dt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // tick input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_word_t           in_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_word_t          out_data_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg;
  in_word_t  in_q;
  logic      in_valid_q;
  out_word_t res;
  out_word_t out_q;
  logic      out_valid_q;
  logic      in_accept;
  logic      advance;

  // tick advances when the result register is free or being drained
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  ps2dt_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sender state and tick update
  ps2dt_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .word_i    (in_q),
    .cfg_i     (cfg),
    .word_o    (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### sv/ps2dt_apb_regs.sv
// ----------------------------------------------------------------------------
// ps2dt_apb_regs
// apb register file holding the clock period and pretransmit time
// ----------------------------------------------------------------------------
`default_nettype none

module ps2dt_apb_regs
  import ps2dt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_CLOCK_PERIOD: cfg_d.clock_period_ns = pwdata[CFG_W-1:0];
        REG_PRETRANSMIT:  cfg_d.pretransmit_ns  = pwdata[CFG_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_period_ns <= CLOCK_PERIOD_RST;
      cfg_q.pretransmit_ns  <= PRETRANSMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CLOCK_PERIOD: prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg_q.clock_period_ns};
      REG_PRETRANSMIT:  prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg_q.pretransmit_ns};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/ps2dt_core.sv
// ----------------------------------------------------------------------------
// ps2dt_core
// sender state and the per-tick update of phase, timer and line drives
// ----------------------------------------------------------------------------
`default_nettype none

module ps2dt_core
  import ps2dt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_en_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output out_word_t word_o
);

`include "ps2_device_scan_code_transmitter_defines.svh"

  phase_e      phase_q, phase_d, phase_eff;
  logic [31:0] elapsed_q, elapsed_d;
  logic [7:0]  seq_q [SEQ_DEPTH];
  logic [7:0]  seq_d [SEQ_DEPTH];
  logic [2:0]  seq_idx_q, seq_idx_d;
  logic [7:0]  cur_byte_q, cur_byte_d;
  logic [3:0]  bit_pos_q, bit_pos_d;
  logic        clk_drv_q, clk_drv_d;
  logic        dat_drv_q, dat_drv_d;

  logic [32:0] sum;
  logic [31:0] el;
  logic [31:0] quarter, half, pretx;
  logic [7:0]  next_byte;
  logic [2:0]  bit_sel;
  logic        taken;

  assign quarter = {14'd0, cfg_i.clock_period_ns[CFG_W-1:2]};
  assign half    = {13'd0, cfg_i.clock_period_ns[CFG_W-1:1]};
  assign pretx   = {12'd0, cfg_i.pretransmit_ns};

  // saturating elapsed time
  assign sum = {1'b0, elapsed_q} + {17'd0, word_i.step_ns};
  assign el  = sum[32] ? '1 : sum[31:0];

  assign phase_eff = word_i.host_clock_level ? phase_q : PH_INHIBIT;
  assign next_byte = (seq_idx_q < 3'(SEQ_DEPTH)) ? seq_q[seq_idx_q[1:0]] : BYTE_END;
  assign bit_sel   = 3'(bit_pos_q - 4'd1);

  always_comb begin
    phase_d    = phase_eff;
    elapsed_d  = el;
    seq_d      = seq_q;
    seq_idx_d  = seq_idx_q;
    cur_byte_d = cur_byte_q;
    bit_pos_d  = bit_pos_q;
    clk_drv_d  = clk_drv_q;
    dat_drv_d  = dat_drv_q;
    taken      = 1'b0;

    unique case (phase_eff)
      PH_INHIBIT: begin
        clk_drv_d = 1'b1;
        dat_drv_d = 1'b1;
        if (word_i.host_clock_level) begin
          phase_d = PH_PRETX;
        end
        elapsed_d = '0;
      end
      PH_PRETX: begin
        if (el >= pretx) begin
          elapsed_d = pretx;
          if (word_i.key_valid) begin
            taken = 1'b1;
            for (int i = 0; i < SEQ_DEPTH; i++) begin
              seq_d[i] = BYTE_END;
            end
            unique case ({word_i.key_extended, word_i.key_release})
              2'b00: seq_d[0] = word_i.key_code;
              2'b01: begin
                seq_d[0] = PREFIX_BREAK;
                seq_d[1] = word_i.key_code;
              end
              2'b10: begin
                seq_d[0] = PREFIX_EXTENDED;
                seq_d[1] = word_i.key_code;
              end
              default: begin
                seq_d[0] = PREFIX_EXTENDED;
                seq_d[1] = PREFIX_BREAK;
                seq_d[2] = word_i.key_code;
              end
            endcase
            phase_d   = PH_CLKHIGH;
            seq_idx_d = '0;
            bit_pos_d = FRAME_END;
            elapsed_d = '0;
          end
        end
      end
      PH_DATA: begin
        // start, data lsb first, parity, then released
        priority if (bit_pos_q == 4'd0) begin
          dat_drv_d = 1'b0;
        end else if (bit_pos_q <= 4'd8) begin
          dat_drv_d = cur_byte_q[bit_sel];
        end else if (bit_pos_q == 4'd9) begin
          dat_drv_d = odd_parity(cur_byte_q);
        end else begin
          dat_drv_d = 1'b1;
        end
        if (el >= quarter) begin
          phase_d   = PH_CLKLOW;
          elapsed_d = el - quarter;
        end
      end
      PH_CLKLOW: begin
        clk_drv_d = 1'b0;
        if (el >= half) begin
          phase_d   = PH_CLKHIGH;
          elapsed_d = el - half;
        end
      end
      default: begin
        // clock high
        clk_drv_d = 1'b1;
        if (el >= quarter) begin
          if (bit_pos_q >= FRAME_END) begin
            if (next_byte == BYTE_END) begin
              phase_d   = PH_PRETX;
              elapsed_d = pretx;
            end else begin
              phase_d    = PH_DATA;
              cur_byte_d = next_byte;
              seq_idx_d  = seq_idx_q + 3'd1;
              bit_pos_d  = '0;
              elapsed_d  = '0;
            end
          end else begin
            phase_d   = PH_DATA;
            bit_pos_d = bit_pos_q + 4'd1;
            elapsed_d = el - quarter;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_PRETX;
      elapsed_q  <= '0;
      for (int i = 0; i < SEQ_DEPTH; i++) begin
        seq_q[i] <= BYTE_END;
      end
      seq_idx_q  <= '0;
      cur_byte_q <= '0;
      bit_pos_q  <= '0;
      clk_drv_q  <= 1'b1;
      dat_drv_q  <= 1'b1;
    end else if (step_en_i) begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      seq_q      <= seq_d;
      seq_idx_q  <= seq_idx_d;
      cur_byte_q <= cur_byte_d;
      bit_pos_q  <= bit_pos_d;
      clk_drv_q  <= clk_drv_d;
      dat_drv_q  <= dat_drv_d;
    end
  end

  assign word_o.clock_line = word_i.host_clock_level & clk_drv_d;
  assign word_o.data_line  = word_i.host_data_level & dat_drv_d;
  assign word_o.key_taken  = taken;
  assign word_o.phase      = phase_d;

  `PS2DT_ASSERT(a_bit_pos_range, bit_pos_q <= FRAME_END, "bit position past frame end")
  `PS2DT_ASSERT(a_seq_idx_range, seq_idx_q <= 3'd3, "sequence index past last byte")
  `PS2DT_ASSERT_IMPL(a_take_in_pretx, step_en_i && taken,
    phase_q == PH_PRETX && word_i.host_clock_level, "key taken outside pretransmit")
  `PS2DT_ASSERT_NEXT(a_take_starts_frame, step_en_i && taken,
    phase_q == PH_CLKHIGH && bit_pos_q == FRAME_END, "taken key did not start a frame")
  `PS2DT_ASSERT_NEXT(a_hold_when_idle, !step_en_i,
    $stable(phase_q) && $stable(elapsed_q), "state moved without a step")

endmodule

`default_nettype wire

### sim/ps2_device_scan_code_transmitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_device_scan_code_transmitter_tb
// drives timed host-line ticks and key events into the ps2 device sender and
// checks every result word against a typed-in result or a cycle-free model
// of the five-phase sender kept in this bench, across several timing register settings
// ----------------------------------------------------------------------------
module ps2_device_scan_code_transmitter_tb;
  import ps2dt_pkg::*;

  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned PLAN_N          = 7;
  localparam int unsigned QUIET_PHASE     = 2;
  localparam int unsigned DIR_N           = 24;

  // one directed row: the tick word and, where obvious, its result typed in
  typedef struct {
    in_word_t  w;
    logic      typed;
    out_word_t o;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_word_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_word_t          out_data_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // typed-in result riding alongside the word on the input channel
  logic      typed_row = 1'b0;
  out_word_t typed_levels = '0;

  // random idling of both sides
  bit allow_gaps = 1'b1;
  bit allow_stall = 1'b1;

  out_word_t   pending_levels [$];
  out_word_t   want;
  out_word_t   predicted;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  dir_row_t dir_tab [DIR_N];
  cfg_t     plan [PLAN_N];

  // sender model: timing registers and state
  logic [CFG_W-1:0] period_ns = CLOCK_PERIOD_RST;
  logic [CFG_W-1:0] pretx_ns  = PRETRANSMIT_RST;
  phase_e           sender_ph = PH_PRETX;
  logic [31:0]      elapsed   = '0;
  logic [7:0]       scan_seq [SEQ_DEPTH] = '{default: BYTE_END};
  logic [2:0]       seq_idx   = '0;
  logic [7:0]       cur_byte  = '0;
  logic [3:0]       bit_pos   = '0;
  logic             model_clk = 1'b1;
  logic             model_dat = 1'b1;

  ps2_device_scan_code_transmitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // advance the sender by one tick and return the line levels after it
  function automatic out_word_t advance_sender(input in_word_t w);
    logic [31:0] quarter;
    logic [31:0] half;
    logic        taken;
    logic [7:0]  nxt;
    int          n;
    out_word_t   r;
    quarter = {12'd0, period_ns} >> 2;
    half    = {12'd0, period_ns} >> 1;
    taken   = 1'b0;
    // host holding the clock low wins over everything
    if (!w.host_clock_level) sender_ph = PH_INHIBIT;
    if (elapsed > 32'hFFFF_FFFF - {16'd0, w.step_ns}) elapsed = '1;
    else elapsed = elapsed + {16'd0, w.step_ns};
    case (sender_ph)
      PH_INHIBIT: begin
        model_clk = 1'b1;
        model_dat = 1'b1;
        if (w.host_clock_level) sender_ph = PH_PRETX;
        elapsed = '0;
      end
      PH_PRETX: begin
        if (elapsed >= {12'd0, pretx_ns}) begin
          // hold at the pretransmit mark until a key shows up
          elapsed = {12'd0, pretx_ns};
          if (w.key_valid) begin
            taken    = 1'b1;
            scan_seq = '{default: BYTE_END};
            n = 0;
            if (w.key_extended) begin
              scan_seq[n] = PREFIX_EXTENDED;
              n++;
            end
            if (w.key_release) begin
              scan_seq[n] = PREFIX_BREAK;
              n++;
            end
            scan_seq[n] = w.key_code;
            sender_ph = PH_CLKHIGH;
            seq_idx   = '0;
            bit_pos   = FRAME_END;
            elapsed   = '0;
          end
        end
      end
      PH_DATA: begin
        // start bit, data lsb first, odd parity, then stop
        if (bit_pos == 4'd0) model_dat = 1'b0;
        else if (bit_pos <= 4'd8) model_dat = cur_byte[bit_pos - 4'd1];
        else if (bit_pos == 4'd9) model_dat = ~(^cur_byte);
        else model_dat = 1'b1;
        if (elapsed >= quarter) begin
          sender_ph = PH_CLKLOW;
          elapsed   = elapsed - quarter;
        end
      end
      PH_CLKLOW: begin
        model_clk = 1'b0;
        if (elapsed >= half) begin
          sender_ph = PH_CLKHIGH;
          elapsed   = elapsed - half;
        end
      end
      default: begin
        model_clk = 1'b1;
        if (elapsed >= quarter) begin
          if (bit_pos >= FRAME_END) begin
            // frame done: next byte, or back to pretransmit on a zero byte
            nxt = (seq_idx < SEQ_DEPTH) ? scan_seq[seq_idx[1:0]] : BYTE_END;
            if (nxt == BYTE_END) begin
              sender_ph = PH_PRETX;
              elapsed   = {12'd0, pretx_ns};
            end else begin
              sender_ph = PH_DATA;
              cur_byte  = nxt;
              seq_idx   = seq_idx + 3'd1;
              bit_pos   = '0;
              elapsed   = '0;
            end
          end else begin
            sender_ph = PH_DATA;
            bit_pos   = bit_pos + 4'd1;
            elapsed   = elapsed - quarter;
          end
        end
      end
    endcase
    r.clock_line = w.host_clock_level & model_clk;
    r.data_line  = w.host_data_level & model_dat;
    r.key_taken  = taken;
    r.phase      = sender_ph;
    return r;
  endfunction

  // present one word, with random gaps ahead of it, until it is taken
  task automatic send_tick(input in_word_t w, input logic typed, input out_word_t lv);
    while (allow_gaps && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_data_i    <= w;
    typed_row    <= typed;
    typed_levels <= lv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop sending and wait for every expected result word
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write: setup then access, committed on the ready edge
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(PDATA_W-CFG_W){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CLOCK_PERIOD) period_ns = val;
    else pretx_ns = val;
  endtask

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= allow_stall && ($urandom_range(99) < 25);
  end

  // result checking, then prediction for the word taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_levels.size() == 0) begin
          $error("result word with nothing expected: %h", out_data_o);
          mismatches++;
        end else begin
          want = pending_levels.pop_front();
          if (out_data_o.clock_line !== want.clock_line) begin
            $error("clock_line: expected %0d, got %0d", want.clock_line, out_data_o.clock_line);
            mismatches++;
          end
          if (out_data_o.data_line !== want.data_line) begin
            $error("data_line: expected %0d, got %0d", want.data_line, out_data_o.data_line);
            mismatches++;
          end
          if (out_data_o.key_taken !== want.key_taken) begin
            $error("key_taken: expected %0d, got %0d", want.key_taken, out_data_o.key_taken);
            mismatches++;
          end
          if (out_data_o.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, out_data_o.phase);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predicted = advance_sender(in_data_i);
        pending_levels.push_back(typed_row ? typed_levels : predicted);
      end
    end
  end

  // cycles in which no word moves on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("ps2_device_scan_code_transmitter: mismatch");
    $finish;
  end

  initial begin
    in_word_t    w;
    int unsigned span;
    int unsigned roll;

    // directed ticks at the reset timing: quarter 14970, half 29940
    // fields: step, host clock, host data, key valid, release, extended, code
    dir_tab = '{
      // idle after reset
      '{{16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b1, {1'b1, 1'b1, 1'b0, PH_PRETX}},
      // host clock low with every key field high: inhibit
      '{{16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF}, 1'b1,
        {1'b0, 1'b0, 1'b0, PH_INHIBIT}},
      '{{16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b1, {1'b1, 1'b1, 1'b0, PH_PRETX}},
      // key offered one ns short of the pretransmit time
      '{{16'd49999, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h1C}, 1'b1,
        {1'b1, 1'b1, 1'b0, PH_PRETX}},
      // make of code zero is taken but sends nothing
      '{{16'd1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00}, 1'b1, {1'b1, 1'b1, 1'b1, PH_CLKHIGH}},
      '{{16'd14970, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b1,
        {1'b1, 1'b1, 1'b0, PH_PRETX}},
      // extended break of 0xff, taken at once since elapsed is held
      '{{16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF}, 1'b1, {1'b1, 1'b1, 1'b1, PH_CLKHIGH}},
      '{{16'd14970, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'd14970, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      // host pulls data low mid-frame
      '{{16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'd29940, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      // key offered while busy is ignored
      '{{16'd14970, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h5A}, 1'b0, '0},
      '{{16'd14970, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'd29940, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      // host clock low aborts the frame
      '{{16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      // plain break after the abort
      '{{16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h80}, 1'b0, '0},
      '{{16'd14970, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'd14970, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'd29940, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'd14970, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{{16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0}
    };

    // timing settings: both extremes, a tiny period, a few in between,
    // and back to the reset values
    plan = '{
      {20'd4,       20'd0},
      {20'd3,       20'd0},
      {20'd200,     20'd100},
      {20'd1000000, 20'd1000000},
      {20'd64,      20'd37},
      {20'd1000,    20'd0},
      {20'd59880,   20'd50000}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_tick(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].o);
    end
    // the bench holds off until every result is back before the first write
    drain_results();

    for (int p = 0; p < PLAN_N; p++) begin
      write_reg(REG_CLOCK_PERIOD, plan[p].clock_period_ns);
      write_reg(REG_PRETRANSMIT, plan[p].pretransmit_ns);
      // one setting runs with no idling on either side
      allow_gaps  = (p != QUIET_PHASE);
      allow_stall = (p != QUIET_PHASE);
      // steps mostly up to half a period so frames walk through every bit
      span = {12'd0, plan[p].clock_period_ns} / 2 + 1;
      if (span > 65535) span = 65535;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        roll = $urandom_range(9);
        if (roll == 0) w.step_ns = '0;
        else if (roll == 1) w.step_ns = '1;
        else if (roll == 2) w.step_ns = 16'($urandom_range(3));
        else w.step_ns = 16'($urandom_range(span));
        // mostly a quiet host, now and then an inhibit
        w.host_clock_level = ($urandom_range(99) >= 3);
        w.host_data_level  = ($urandom_range(99) >= 10);
        w.key_valid        = ($urandom_range(99) < 60);
        w.key_release      = 1'($urandom_range(1));
        w.key_extended     = 1'($urandom_range(1));
        w.key_code         = ($urandom_range(99) < 5) ? 8'h00 : 8'($urandom_range(255, 1));
        send_tick(w, 1'b0, '0);
      end
      drain_results();
    end

    allow_gaps  = 1'b1;
    allow_stall = 1'b1;
    repeat (8) @(posedge clk_i);
    if (pending_levels.size() != 0) begin
      $error("%0d result words never arrived", pending_levels.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ps2_device_scan_code_transmitter: match");
    end else begin
      $display("ps2_device_scan_code_transmitter: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/ps2dt_pkg.sv
sv/ps2dt_apb_regs.sv
sv/ps2dt_core.sv
sv/ps2_device_scan_code_transmitter.sv
sim/ps2_device_scan_code_transmitter_tb.sv
